### rtl/matm_pkg.sv
// Shared types, operation codes and arithmetic helpers for the alarm time matcher.
`default_nettype none

package matm_pkg;

    // Table size limits
    localparam int ALARM_MAX       = 8;
    localparam int ALARM_COUNT_DEF = 8;

    // Operation codes
    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_ENABLE  = 3'd1;
    localparam logic [2:0] OP_DISABLE = 3'd2;
    localparam logic [2:0] OP_SNOOZE  = 3'd3;
    localparam logic [2:0] OP_CHECK   = 3'd4;

    // Reciprocal constants: x / 60 = (x * 34953) >> 21 for x < 2^16,
    // x / 24 = (x * 2731) >> 16 for x < 2^11
    localparam logic [15:0] DIV60_MUL = 16'd34953;
    localparam logic [11:0] DIV24_MUL = 12'd2731;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  alarm_index;
        logic [7:0]  alarm_hour_bcd;
        logic [7:0]  alarm_minute_bcd;
        logic [15:0] snooze_minutes;
        logic [7:0]  now_hour_bcd;
        logic [7:0]  now_minute_bcd;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic       fired;
        logic [2:0] fired_index;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic table_wr;
        logic scan_clear;
        logic scan_issue;
        logic out_load;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_check;
        logic scan_done;
    } dp_status_t;

    // BCD byte to binary, nibbles taken at face value (max 165)
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return ({hi[4:0], 3'b0} + {hi[6:0], 1'b0}) + {4'b0, b[3:0]};
    endfunction

    // Binary value below 60 to two BCD digits
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        if (v >= 6'd50) begin
            tens = 3'd5;
            ones = v - 6'd50;
        end else if (v >= 6'd40) begin
            tens = 3'd4;
            ones = v - 6'd40;
        end else if (v >= 6'd30) begin
            tens = 3'd3;
            ones = v - 6'd30;
        end else if (v >= 6'd20) begin
            tens = 3'd2;
            ones = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens = 3'd1;
            ones = v - 6'd10;
        end else begin
            tens = 3'd0;
            ones = v;
        end
        return {1'b0, tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/matm_in_if.sv
// Valid/ready channel carrying one request item.
`default_nettype none

interface matm_in_if import matm_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/matm_out_if.sv
// Valid/ready channel carrying one result item.
`default_nettype none

interface matm_out_if import matm_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/matm_ctrl.sv
// Controller: sequences item decode, table writes, the alarm scan and result hand-off.
`default_nettype none

module matm_ctrl import matm_pkg::*; #(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire dp_status_t          status,
    output ctl_cmd_t                 ctl,
    output logic [((ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1)-1:0] scan_idx
);

    localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_DRAIN    = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_check)
                begin
                    ctl.scan_clear = 1'b1;
                    idx_next       = '0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    ctl.table_wr = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign scan_idx  = idx_reg;

`ifndef SYNTHESIS
    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // The last scan result moves the controller to the response state
    a_drain_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && status.scan_done) |=> (state_reg == S_RESP))
        else $error("scan completion missed");
`endif

endmodule

`default_nettype wire

### rtl/matm_dp.sv
// Datapath: alarm table, snooze offset pipeline, match collection and result register.
`default_nettype none

module matm_dp import matm_pkg::*; #(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    in_item,
    input  wire ctl_cmd_t    ctl,
    input  wire logic [((ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1)-1:0] scan_idx,
    output dp_status_t       status,
    output out_item_t        out_item
);

    localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);

    // Latched request item
    in_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= in_item;
        end
    end

    logic             idx_ok;
    logic             is_table_op;
    logic [IDX_W-1:0] wr_idx;

    assign idx_ok      = (item_reg.alarm_index < 8'(ALARM_COUNT));
    assign is_table_op = (item_reg.operation <= OP_SNOOZE);
    assign wr_idx      = item_reg.alarm_index[IDX_W-1:0];

    // Alarm table
    logic [7:0]  hour_reg  [ALARM_COUNT];
    logic [7:0]  min_reg   [ALARM_COUNT];
    logic [15:0] snz_reg   [ALARM_COUNT];
    logic        armed_reg [ALARM_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ALARM_COUNT; k++)
            begin
                hour_reg[k]  <= '0;
                min_reg[k]   <= '0;
                snz_reg[k]   <= '0;
                armed_reg[k] <= 1'b0;
            end
        end
        else if (ctl.table_wr && idx_ok)
        begin
            unique case (item_reg.operation)
                OP_SET:
                begin
                    hour_reg[wr_idx]  <= item_reg.alarm_hour_bcd;
                    min_reg[wr_idx]   <= item_reg.alarm_minute_bcd;
                    snz_reg[wr_idx]   <= '0;
                    armed_reg[wr_idx] <= 1'b1;
                end
                OP_ENABLE:
                begin
                    snz_reg[wr_idx]   <= '0;
                    armed_reg[wr_idx] <= 1'b1;
                end
                OP_DISABLE:
                begin
                    snz_reg[wr_idx]   <= '0;
                    armed_reg[wr_idx] <= 1'b0;
                end
                OP_SNOOZE:
                begin
                    snz_reg[wr_idx] <= item_reg.snooze_minutes;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stage valids
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= ctl.scan_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // Sideband carried along the pipeline
    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic             s1_arm_reg, s2_arm_reg, s3_arm_reg, s4_arm_reg;
    logic             s1_zero_reg, s2_zero_reg, s3_zero_reg, s4_zero_reg;
    logic [7:0]       s1_rawh_reg, s2_rawh_reg, s3_rawh_reg, s4_rawh_reg;
    logic [7:0]       s1_rawm_reg, s2_rawm_reg, s3_rawm_reg, s4_rawm_reg;

    // Stage 1: table read, BCD to binary, snooze times 1/60 product
    logic [15:0] s1_snz_reg;
    logic [31:0] s1_prod_reg;
    logic [7:0]  s1_hb_reg, s1_mb_reg;

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= scan_idx;
        s1_arm_reg  <= armed_reg[scan_idx];
        s1_zero_reg <= (snz_reg[scan_idx] == 16'd0);
        s1_rawh_reg <= hour_reg[scan_idx];
        s1_rawm_reg <= min_reg[scan_idx];
        s1_snz_reg  <= snz_reg[scan_idx];
        s1_prod_reg <= {16'b0, snz_reg[scan_idx]} * {16'b0, DIV60_MUL};
        s1_hb_reg   <= bcd_to_bin(hour_reg[scan_idx]);
        s1_mb_reg   <= bcd_to_bin(min_reg[scan_idx]);
    end

    // Stage 2: quotient and remainder by 60, add stored time
    logic [10:0] s2_q;
    logic [16:0] s2_q60;
    logic [16:0] s2_rem;
    logic [7:0]  s2_m_next;
    logic [10:0] s2_h_next;
    logic [7:0]  s2_m_reg;
    logic [10:0] s2_h_reg;

    assign s2_q      = s1_prod_reg[31:21];
    assign s2_q60    = {s2_q, 6'b0} - {4'b0, s2_q, 2'b0};
    assign s2_rem    = {1'b0, s1_snz_reg} - s2_q60;
    assign s2_m_next = {2'b0, s2_rem[5:0]} + s1_mb_reg;
    assign s2_h_next = s2_q + {3'b0, s1_hb_reg};

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_arm_reg  <= s1_arm_reg;
        s2_zero_reg <= s1_zero_reg;
        s2_rawh_reg <= s1_rawh_reg;
        s2_rawm_reg <= s1_rawm_reg;
        s2_m_reg    <= s2_m_next;
        s2_h_reg    <= s2_h_next;
    end

    // Stage 3: wrap minutes at 60, carry into hours
    logic [7:0]  s3_m_wide;
    logic [1:0]  s3_carry;
    logic [5:0]  s3_m_reg;
    logic [10:0] s3_h_reg;

    always_comb
    begin
        if (s2_m_reg >= 8'd180)
        begin
            s3_m_wide = s2_m_reg - 8'd180;
            s3_carry  = 2'd3;
        end
        else if (s2_m_reg >= 8'd120)
        begin
            s3_m_wide = s2_m_reg - 8'd120;
            s3_carry  = 2'd2;
        end
        else if (s2_m_reg >= 8'd60)
        begin
            s3_m_wide = s2_m_reg - 8'd60;
            s3_carry  = 2'd1;
        end
        else
        begin
            s3_m_wide = s2_m_reg;
            s3_carry  = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_idx_reg  <= s2_idx_reg;
        s3_arm_reg  <= s2_arm_reg;
        s3_zero_reg <= s2_zero_reg;
        s3_rawh_reg <= s2_rawh_reg;
        s3_rawm_reg <= s2_rawm_reg;
        s3_m_reg    <= s3_m_wide[5:0];
        s3_h_reg    <= s2_h_reg + {9'b0, s3_carry};
    end

    // Stage 4: hours times 1/24 product
    logic [22:0] s4_prod_reg;
    logic [10:0] s4_h_reg;
    logic [5:0]  s4_m_reg;

    always_ff @(posedge clk)
    begin
        s4_idx_reg  <= s3_idx_reg;
        s4_arm_reg  <= s3_arm_reg;
        s4_zero_reg <= s3_zero_reg;
        s4_rawh_reg <= s3_rawh_reg;
        s4_rawm_reg <= s3_rawm_reg;
        s4_prod_reg <= {12'b0, s3_h_reg} * {11'b0, DIV24_MUL};
        s4_h_reg    <= s3_h_reg;
        s4_m_reg    <= s3_m_reg;
    end

    // Hour modulo 24, back to BCD, compare against the current time
    logic [5:0]  s4_hq;
    logic [10:0] s4_hq24;
    logic [10:0] s4_hr;
    logic [7:0]  eff_h, eff_m;
    logic        match;

    assign s4_hq   = s4_prod_reg[21:16];
    assign s4_hq24 = {1'b0, s4_hq, 4'b0} + {2'b0, s4_hq, 3'b0};
    assign s4_hr   = s4_h_reg - s4_hq24;
    assign eff_h   = s4_zero_reg ? s4_rawh_reg : bin_to_bcd({1'b0, s4_hr[4:0]});
    assign eff_m   = s4_zero_reg ? s4_rawm_reg : bin_to_bcd(s4_m_reg);
    assign match   = s4_v_reg && s4_arm_reg
                     && (eff_h == item_reg.now_hour_bcd)
                     && (eff_m == item_reg.now_minute_bcd);

    // Match collection
    logic [ALARM_COUNT-1:0] hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (ctl.scan_clear)
        begin
            hit_reg <= '0;
        end
        else if (match)
        begin
            hit_reg[s4_idx_reg] <= 1'b1;
        end
    end

    assign status.is_check  = (item_reg.operation == OP_CHECK);
    assign status.scan_done = s4_v_reg && (s4_idx_reg == LAST_IDX);

    // Lowest matching alarm
    logic [2:0] low_idx;

    always_comb
    begin
        low_idx = 3'd0;
        for (int k = ALARM_COUNT - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
            begin
                low_idx = 3'(k);
            end
        end
    end

    // Result register
    out_item_t out_next;
    out_item_t out_reg;

    always_comb
    begin
        out_next = '0;
        case (item_reg.operation) inside
            OP_SET, OP_ENABLE, OP_DISABLE, OP_SNOOZE:
            begin
                out_next.accepted = idx_ok;
            end
            OP_CHECK:
            begin
                out_next.fired       = |hit_reg;
                out_next.fired_index = low_idx;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

`ifndef SYNTHESIS
    // Table writes never overlap an in-flight scan
    a_wr_not_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.table_wr |-> !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg))
        else $error("table write during scan");

    // A check result is taken only once the pipeline has drained
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.out_load && is_table_op == 1'b0)
            |-> !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg))
        else $error("result loaded with scan in flight");
`endif

endmodule

`default_nettype wire

### rtl/multi_alarm_time_matcher.sv
// Top level of the multi-alarm time matcher: controller, datapath and channel wiring.
//
// Holds ALARM_COUNT alarms (BCD hour and minute, snooze offset, armed flag). One request
// item is handled at a time and gives one result item. A table operation (set, enable,
// disable, snooze) writes the table, then loads its result once the output register is
// free; unused operation codes take the same path. A check scans the table one alarm per
// cycle through a four-stage offset pipeline (divide by 60, minute wrap, divide by 24,
// BCD compare) and loads its result likewise once the last alarm leaves the pipeline.
// A new item is accepted as soon as the block is back in idle, even while the previous
// result still waits in the output register. The table resets to all alarms disarmed.
`default_nettype none

module multi_alarm_time_matcher import matm_pkg::*; #(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    matm_in_if.sink    cmd,
    matm_out_if.source rsp
);

    localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

    ctl_cmd_t         ctl;
    dp_status_t       status;
    logic [IDX_W-1:0] scan_idx;
    logic             in_ready;
    logic             out_valid;
    out_item_t        out_item;

    matm_ctrl #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .ctl       (ctl),
        .scan_idx  (scan_idx)
    );

    matm_dp #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (cmd.data),
        .ctl      (ctl),
        .scan_idx (scan_idx),
        .status   (status),
        .out_item (out_item)
    );

    assign cmd.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = out_item;

endmodule

`default_nettype wire
